// ----- sv/sssc_pkg.sv -----
// ----------------------------------------------------------------------------
// sssc_pkg: shared types and constants of the servo step slew controller
// Command and status bundles between the sequencer and the datapath, the
// register index codes and the angle limits.
// ----------------------------------------------------------------------------
package sssc_pkg;

  // Angle range in degrees
  localparam logic [7:0] ANGLE_MAX = 8'd180;

  // Field widths fixed by the word layout
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned READ_W   = 10;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned IN_DW    = 56;
  localparam int unsigned OUT_DW   = 16;

  // Register index codes
  typedef enum logic [CFG_AW-1:0] {
    CFG_CALIB_LOW   = 3'd0,
    CFG_CALIB_HIGH  = 3'd1,
    CFG_STEP_SIZE   = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_INTERVAL    = 3'd4
  } cfg_idx_t;

  // Sequencer to datapath
  typedef struct packed {
    logic load_in;     // capture the input word
    logic load_div;    // set up the divider from the captured word
    logic store_time;  // keep the timestamp as the last step time
    logic div_step;    // one restoring division step
    logic emit;        // update the drive angle and load the output word
  } cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic elapsed_ok;  // interval since the last step has run out
    logic in_tol;      // measured angle lies within tolerance of target
    logic out_busy;    // output word still waits to be taken
  } sts_t;

endpackage

// ----- sv/sssc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sssc_ctrl: sequencer of the servo step slew controller
// Walks each word through the interval check, the iterative calibration
// divide and the tolerance decision, and issues datapath commands.
// ----------------------------------------------------------------------------
module sssc_ctrl #(
  parameter int unsigned DIV_STEPS = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sssc_pkg::sts_t   sts,
  output sssc_pkg::cmd_t   cmd
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATE,
    S_DIV,
    S_DECIDE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_GATE;
        end
      end
      S_GATE: begin
        cmd.load_div = 1'b1;
        cnt_nxt      = '0;
        if (sts.elapsed_ok) begin
          cmd.store_time = 1'b1;
          state_nxt      = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.in_tol) begin
          state_nxt = S_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // Division runs its full length before any decision
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_DECIDE))
    else $error("division left early or late");

  // Never overwrite a waiting output word
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("emit while output word still waits");

  // Division only starts once the interval check passed
  a_div_gated: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(state_r == S_DIV)) |-> $past(sts.elapsed_ok))
    else $error("division started without interval check");
`endif

endmodule

// ----- sv/sssc_dp.sv -----
// ----------------------------------------------------------------------------
// sssc_dp: datapath of the servo step slew controller
// Holds the registers, the step timestamp and drive angle, the restoring
// divider of the calibration map, the step logic and the output word.
// ----------------------------------------------------------------------------
module sssc_dp #(
  parameter int unsigned ADC_BITS  = 10,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned NUM_W     = ADC_BITS + 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [sssc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [sssc_pkg::CFG_DW-1:0]   cfg_wdata,
  // input word fields
  input  logic [sssc_pkg::NOW_W-1:0]    now_ms,
  input  logic [sssc_pkg::ANGLE_W-1:0]  target_angle,
  input  logic [sssc_pkg::READ_W-1:0]   feedback_reading,
  // result word
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sssc_pkg::ANGLE_W-1:0]  commanded_angle,
  output logic [sssc_pkg::ANGLE_W-1:0]  measured_angle,
  // sequencer
  input  sssc_pkg::cmd_t                cmd,
  output sssc_pkg::sts_t                sts
);

  // Configuration registers
  logic [sssc_pkg::READ_W-1:0]  calib_low_r, calib_high_r;
  logic [7:0]                   step_size_r, tolerance_r;
  logic [15:0]                  interval_r;

  // Captured word and held state
  logic [TIME_BITS-1:0]         now_r, last_r;
  logic [7:0]                   target_r, drive_r;
  logic [sssc_pkg::READ_W-1:0]  reading_r;

  // Divider
  logic [NUM_W-1:0]             quo_r;
  logic [ADC_BITS-1:0]          rem_r, den_r;
  logic                         zero_r;

  // Output word
  logic                         out_valid_r;
  logic [7:0]                   cmd_angle_r, meas_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_low_r  <= '0;
      calib_high_r <= 10'd1023;
      step_size_r  <= 8'd1;
      tolerance_r  <= 8'd1;
      interval_r   <= 16'd20;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        sssc_pkg::CFG_CALIB_LOW:  calib_low_r  <= cfg_wdata[sssc_pkg::READ_W-1:0];
        sssc_pkg::CFG_CALIB_HIGH: calib_high_r <= cfg_wdata[sssc_pkg::READ_W-1:0];
        sssc_pkg::CFG_STEP_SIZE:  step_size_r  <= cfg_wdata[7:0];
        sssc_pkg::CFG_TOLERANCE:  tolerance_r  <= cfg_wdata[7:0];
        sssc_pkg::CFG_INTERVAL:   interval_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Fit the fixed-width fields to the time and converter widths
  logic [63:0]          now_ext, iv_ext;
  logic [15:0]          x_ext, lo_ext, hi_ext;
  logic [TIME_BITS-1:0] now_t, iv_t, elapsed;
  logic [ADC_BITS-1:0]  x_a, lo_a, hi_a;

  assign now_ext = {32'd0, now_ms};
  assign iv_ext  = {48'd0, interval_r};
  assign now_t   = now_ext[TIME_BITS-1:0];
  assign iv_t    = iv_ext[TIME_BITS-1:0];
  assign x_ext   = {6'd0, reading_r};
  assign lo_ext  = {6'd0, calib_low_r};
  assign hi_ext  = {6'd0, calib_high_r};
  assign x_a     = x_ext[ADC_BITS-1:0];
  assign lo_a    = lo_ext[ADC_BITS-1:0];
  assign hi_a    = hi_ext[ADC_BITS-1:0];

  // Wrapping interval check
  assign elapsed        = now_r - last_r;
  assign sts.elapsed_ok = (elapsed >= iv_t);

  // Capture word, keep step time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cmd.store_time) begin
      last_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r     <= now_t;
      target_r  <= target_angle;
      reading_r <= feedback_reading;
    end
  end

  // Calibration map set-up: magnitudes and sign of the quotient
  logic                x_lt_lo, hi_lt_lo;
  logic [ADC_BITS-1:0] dabs, den_abs;
  logic [NUM_W-1:0]    num_abs;

  assign x_lt_lo  = (x_a < lo_a);
  assign hi_lt_lo = (hi_a < lo_a);
  assign dabs     = x_lt_lo  ? (lo_a - x_a)  : (x_a - lo_a);
  assign den_abs  = hi_lt_lo ? (lo_a - hi_a) : (hi_a - lo_a);
  assign num_abs  = NUM_W'(dabs) * NUM_W'(sssc_pkg::ANGLE_MAX);

  // Restoring division step
  logic [ADC_BITS:0] rem_sh, rem_dif;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_dif = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quo_r  <= num_abs;
      rem_r  <= '0;
      den_r  <= den_abs;
      // zero span, zero offset or negative quotient all read as 0 degrees
      zero_r <= (den_abs == '0) || (dabs == '0) || (x_lt_lo ^ hi_lt_lo);
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_dif[ADC_BITS-1:0] : rem_sh[ADC_BITS-1:0];
    end
  end

  // Saturate the quotient to the angle range
  logic [7:0] meas;
  assign meas = zero_r ? 8'd0 :
                (quo_r > NUM_W'(sssc_pkg::ANGLE_MAX)) ? sssc_pkg::ANGLE_MAX : quo_r[7:0];

  // Tolerance check
  logic [7:0] mag;
  logic       up;
  assign up         = (target_r > meas);
  assign mag        = up ? (target_r - meas) : (meas - target_r);
  assign sts.in_tol = (mag <= tolerance_r);

  // Step the drive angle toward the target, then clamp
  logic signed [9:0] d_s, s_s, t_s, stepped, bounded;
  logic [7:0]        drive_nxt;

  assign d_s = $signed({2'b00, drive_r});
  assign s_s = $signed({2'b00, step_size_r});
  assign t_s = $signed({2'b00, target_r});

  always_comb begin
    if (up) begin
      stepped = d_s + s_s;
      bounded = (stepped > t_s) ? t_s : stepped;
    end else begin
      stepped = d_s - s_s;
      bounded = (stepped < t_s) ? t_s : stepped;
    end
    if (bounded < 10'sd0) begin
      drive_nxt = 8'd0;
    end else if (bounded > $signed({2'b00, sssc_pkg::ANGLE_MAX})) begin
      drive_nxt = sssc_pkg::ANGLE_MAX;
    end else begin
      drive_nxt = bounded[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= 8'd90;
    end else if (cmd.emit) begin
      drive_r <= drive_nxt;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cmd_angle_r <= drive_nxt;
      meas_r      <= meas;
    end
  end

  assign sts.out_busy    = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign commanded_angle = cmd_angle_r;
  assign measured_angle  = meas_r;

`ifndef SYNTHESIS
  // Held drive angle stays inside the servo range
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    drive_r <= sssc_pkg::ANGLE_MAX)
    else $error("drive angle out of range");

  // An emitted word is the new drive angle
  a_emit_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_tvalid && commanded_angle == drive_r))
    else $error("output word does not match drive angle");

  // Measured angle in the output word is saturated
  a_meas_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (measured_angle <= sssc_pkg::ANGLE_MAX))
    else $error("measured angle out of range");
`endif

endmodule

// ----- sv/servo_step_slew_controller.sv -----
// ----------------------------------------------------------------------------
// servo_step_slew_controller: rate-limited servo drive with pot feedback
// Gates update words by a minimum interval, maps the feedback reading to
// degrees through the calibration span and steps the drive angle toward
// the target while the error exceeds the tolerance.
//
//   channel   direction  fields (low bit up)
//   in_       slave      tdata: now_ms[31:0], target_angle[39:32],
//                               feedback_reading[49:40], zero fill
//   out_      master     tdata: commanded_angle[7:0], measured_angle[15:8]
//   cfg_      write      cfg_addr selects the register, cfg_wdata its value
//
// A word that comes too early ends after accept and gate; otherwise it goes on
// through the division steps of the one-bit-per-cycle restoring divider of
// the calibration map and then the decision. One word is in work at a time.
// Reset is synchronous, active low, and needs no clearing pass.
// A waiting output word holds only the final decision cycle; input words
// are taken while it waits.
// ----------------------------------------------------------------------------
module servo_step_slew_controller #(
  parameter int unsigned ADC_BITS  = 10,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [sssc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [sssc_pkg::CFG_DW-1:0]   cfg_wdata,
  // input words
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sssc_pkg::IN_DW-1:0]    in_tdata,   // now_ms, target_angle, feedback_reading
  // result words
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sssc_pkg::OUT_DW-1:0]   out_tdata   // commanded_angle, measured_angle
);

  localparam int unsigned NUM_W = ADC_BITS + 8;

  sssc_pkg::cmd_t cmd;
  sssc_pkg::sts_t sts;
  logic [7:0]     commanded_angle, measured_angle;

  sssc_ctrl #(
    .DIV_STEPS (NUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sssc_dp #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS),
    .NUM_W     (NUM_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .now_ms           (in_tdata[31:0]),
    .target_angle     (in_tdata[39:32]),
    .feedback_reading (in_tdata[49:40]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .commanded_angle  (commanded_angle),
    .measured_angle   (measured_angle),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign out_tdata = {measured_angle, commanded_angle};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for servo_step_slew_controller
// Streams update words (timestamp, target, pot reading) through the block
// under several register settings and checks every drive update word against
// an in-bench slew model. Both stream sides idle in short random bursts, bar the last run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // settle after draining, with a wide margin over the decision path of a word
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam logic [sssc_pkg::CFG_AW-1:0] CFG_UNMAPPED = 3'd7;
  localparam int ANGLE_LIMIT = 180;

  typedef struct packed {
    logic [sssc_pkg::NOW_W-1:0]   now_ms;
    logic [sssc_pkg::ANGLE_W-1:0] target;
    logic [sssc_pkg::READ_W-1:0]  reading;
  } update_word_t;

  // measured angle sits in the upper byte of the result word
  typedef struct packed {
    logic [sssc_pkg::ANGLE_W-1:0] measured;
    logic [sssc_pkg::ANGLE_W-1:0] commanded;
  } drive_update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [sssc_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [sssc_pkg::CFG_DW-1:0]   cfg_wdata = '0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [sssc_pkg::IN_DW-1:0]    in_tdata = '0;   // now_ms, target_angle, feedback_reading
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [sssc_pkg::OUT_DW-1:0]   out_tdata;       // commanded_angle, measured_angle

  servo_step_slew_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Slew model state and register copies
  logic [sssc_pkg::READ_W-1:0]  m_calib_lo;
  logic [sssc_pkg::READ_W-1:0]  m_calib_hi;
  logic [sssc_pkg::ANGLE_W-1:0] m_step;
  logic [sssc_pkg::ANGLE_W-1:0] m_tol;
  logic [15:0]                  m_interval;
  logic [sssc_pkg::NOW_W-1:0]   m_last_time;
  logic [sssc_pkg::ANGLE_W-1:0] m_drive;

  update_word_t  pending_words[$];
  drive_update_t drive_expect_q[$];
  int unsigned   words_queued = 0;
  int unsigned   words_taken = 0;
  int unsigned   updates_checked = 0;
  int unsigned   settings_run = 0;
  int unsigned   error_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   in_gap = 0;
  int unsigned   out_stall = 0;
  bit            quiet_run = 1'b0;
  logic [sssc_pkg::NOW_W-1:0] clock_ms = '0;

  // Map a pot reading to degrees through the calibration span
  function automatic int reading_to_angle(logic [sssc_pkg::READ_W-1:0] reading);
    int lo, hi, span, q;
    lo = int'(m_calib_lo);
    hi = int'(m_calib_hi);
    span = hi - lo;
    if (span == 0) return 0;
    q = ((int'(reading) - lo) * ANGLE_LIMIT) / span;
    if (q < 0) q = 0;
    if (q > ANGLE_LIMIT) q = ANGLE_LIMIT;
    return q;
  endfunction

  // Advance the slew model by one update word; returns 1 when a drive update results
  function automatic bit slew_predict(update_word_t w, output drive_update_t upd);
    logic [sssc_pkg::NOW_W-1:0] elapsed;
    int meas, err, mag, drive, tgt;
    upd = '0;
    elapsed = w.now_ms - m_last_time;
    if (elapsed < {16'd0, m_interval}) return 1'b0;
    m_last_time = w.now_ms;
    meas = reading_to_angle(w.reading);
    tgt = int'(w.target);
    err = tgt - meas;
    mag = (err < 0) ? -err : err;
    if (mag <= int'(m_tol)) return 1'b0;
    drive = int'(m_drive);
    if (err > 0) begin
      drive = drive + int'(m_step);
      if (drive > tgt) drive = tgt;
    end else begin
      drive = drive - int'(m_step);
      if (drive < tgt) drive = tgt;
    end
    if (drive < 0) drive = 0;
    if (drive > ANGLE_LIMIT) drive = ANGLE_LIMIT;
    m_drive = drive[sssc_pkg::ANGLE_W-1:0];
    upd.commanded = m_drive;
    upd.measured = meas[sssc_pkg::ANGLE_W-1:0];
    return 1'b1;
  endfunction

  // Drive one register write at the next edge; caller lowers the enable
  task automatic reg_write(logic [sssc_pkg::CFG_AW-1:0] addr,
                           logic [sssc_pkg::CFG_DW-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    case (addr)
      sssc_pkg::CFG_CALIB_LOW:  m_calib_lo = value[sssc_pkg::READ_W-1:0];
      sssc_pkg::CFG_CALIB_HIGH: m_calib_hi = value[sssc_pkg::READ_W-1:0];
      sssc_pkg::CFG_STEP_SIZE:  m_step = value[sssc_pkg::ANGLE_W-1:0];
      sssc_pkg::CFG_TOLERANCE:  m_tol = value[sssc_pkg::ANGLE_W-1:0];
      sssc_pkg::CFG_INTERVAL:   m_interval = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(int lo, int hi, int step, int tol, int interval);
    reg_write(sssc_pkg::CFG_CALIB_LOW, lo[sssc_pkg::CFG_DW-1:0]);
    reg_write(sssc_pkg::CFG_CALIB_HIGH, hi[sssc_pkg::CFG_DW-1:0]);
    reg_write(sssc_pkg::CFG_STEP_SIZE, step[sssc_pkg::CFG_DW-1:0]);
    reg_write(sssc_pkg::CFG_TOLERANCE, tol[sssc_pkg::CFG_DW-1:0]);
    reg_write(sssc_pkg::CFG_INTERVAL, interval[sssc_pkg::CFG_DW-1:0]);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_run++;
  endtask

  task automatic queue_word(logic [sssc_pkg::NOW_W-1:0] now_ms,
                            logic [sssc_pkg::ANGLE_W-1:0] target,
                            logic [sssc_pkg::READ_W-1:0] reading);
    update_word_t w;
    w.now_ms = now_ms;
    w.target = target;
    w.reading = reading;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Random update words: mostly on schedule, some early, some big jumps
  task automatic queue_random(int count);
    int r, tgt, rd, lo, hi;
    logic [sssc_pkg::NOW_W-1:0] delta;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) delta = m_interval + $urandom_range(0, 5);
      else if (r < 85) delta = (m_interval == 0) ? '0 : $urandom_range(0, m_interval - 1);
      else if (r < 95) delta = $urandom;
      else delta = '0;
      clock_ms = clock_ms + delta;
      tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(181, 255) : $urandom_range(0, 180);
      if ($urandom_range(0, 4) == 0) begin
        // aim the reading near the target to land inside the band
        lo = int'(m_calib_lo);
        hi = int'(m_calib_hi);
        rd = lo + ((tgt > ANGLE_LIMIT ? ANGLE_LIMIT : tgt) * (hi - lo)) / ANGLE_LIMIT
             + int'($urandom_range(0, 4)) - 2;
        if (rd < 0) rd = 0;
        if (rd > 1023) rd = 1023;
      end else begin
        rd = $urandom_range(0, 1023);
      end
      queue_word(clock_ms, tgt[sssc_pkg::ANGLE_W-1:0], rd[sssc_pkg::READ_W-1:0]);
    end
  endtask

  // Hold until every word is taken and every update has come back, then settle
  task automatic drain;
    while (words_taken != words_queued || drive_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input word driver
  always @(posedge clk) begin : word_driver
    update_word_t w;
    drive_update_t upd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        w.now_ms = in_tdata[sssc_pkg::NOW_W-1:0];
        w.target = in_tdata[sssc_pkg::NOW_W+sssc_pkg::ANGLE_W-1:sssc_pkg::NOW_W];
        w.reading = in_tdata[sssc_pkg::NOW_W+sssc_pkg::ANGLE_W+sssc_pkg::READ_W-1:
                             sssc_pkg::NOW_W+sssc_pkg::ANGLE_W];
        if (slew_predict(w, upd)) drive_expect_q.push_back(upd);
        words_taken++;
      end
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0 && (quiet_run || $urandom_range(0, 4) != 0)) begin
        w = pending_words.pop_front();
        in_tdata <= {{(sssc_pkg::IN_DW-sssc_pkg::NOW_W-sssc_pkg::ANGLE_W-
                       sssc_pkg::READ_W){1'b0}}, w.reading, w.target, w.now_ms};
        in_tvalid <= 1'b1;
      end else begin
        if (pending_words.size() != 0) in_gap <= $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result word monitor with random back-pressure
  always @(posedge clk) begin : result_monitor
    drive_update_t want;
    drive_update_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (drive_expect_q.size() == 0) begin
          $display("%0t: unexpected drive update word %h", $realtime, got);
          error_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (got.commanded !== want.commanded) begin
            $display("%0t: commanded_angle expected %0d actual %0d",
                     $realtime, want.commanded, got.commanded);
            error_count++;
          end
          if (got.measured !== want.measured) begin
            $display("%0t: measured_angle expected %0d actual %0d",
                     $realtime, want.measured, got.measured);
            error_count++;
          end
          updates_checked++;
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_tready <= 1'b0;
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: stop when neither side moves a word for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequence: reset, directed words at reset settings, then setting phases
  initial begin
    m_calib_lo = 10'd0;
    m_calib_hi = 10'd1023;
    m_step = 8'd1;
    m_tol = 8'd1;
    m_interval = 16'd20;
    m_last_time = '0;
    m_drive = 8'd90;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    settings_run = 1;

    // interval gate edges, full-scale readings, in-band and wrong-side drive
    queue_word(32'd0, 8'd90, 10'd0);
    queue_word(32'd19, 8'd180, 10'd0);
    queue_word(32'd20, 8'd180, 10'd0);
    queue_word(32'd39, 8'd0, 10'h3FF);
    queue_word(32'd40, 8'd0, 10'h3FF);
    queue_word(32'd60, 8'd90, 10'd511);
    queue_word(32'd80, 8'd255, 10'd0);
    queue_word(32'd100, 8'hAA, 10'h2AA);
    queue_word(32'd120, 8'h55, 10'h155);
    // timestamp wrap around zero
    queue_word(32'hFFFF_FFF0, 8'd0, 10'h3FF);
    queue_word(32'h0000_0003, 8'd0, 10'h3FF);
    queue_word(32'h0000_0004, 8'd0, 10'h3FF);
    queue_word(32'hFFFF_FFFF, 8'd181, 10'd0);
    queue_word(32'h5555_5555, 8'h55, 10'h2AA);
    queue_word(32'hAAAA_AAAA, 8'hAA, 10'h155);
    clock_ms = 32'hAAAA_AAAA;
    drain();

    load_settings(0, 1023, 5, 3, 10);
    queue_random(100);
    drain();

    // reversed span
    load_settings(1000, 24, 12, 2, 3);
    queue_random(90);
    drain();

    // zero span, zero step
    load_settings(512, 512, 0, 10, 7);
    queue_random(70);
    drain();

    // widest band, longest interval
    load_settings(300, 700, 1, 180, 65535);
    queue_random(60);
    drain();

    // full reversed span, largest step, no band, no interval; unmapped index ignored
    reg_write(CFG_UNMAPPED, 16'hFFFF);
    load_settings(1023, 0, 180, 0, 0);
    queue_random(100);
    drain();

    // last stretch at random settings with both sides always ready
    quiet_run = 1'b1;
    load_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(1, 180),
                  $urandom_range(0, 30), $urandom_range(0, 40));
    queue_random(130);
    drain();

    $display("Sent %0d update words under %0d register settings; %0d drive updates checked.",
             words_taken, settings_run, updates_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
